// File: rtl/dtfs_pkg.sv
`default_nettype none

package dtfs_pkg;

  // Request codes
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_UP   = 2'd1,
    OP_DOWN = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    FLD_YEAR   = 3'd0,
    FLD_MONTH  = 3'd1,
    FLD_DAY    = 3'd2,
    FLD_HOUR   = 3'd3,
    FLD_MINUTE = 3'd4
  } field_t;

  // Register index (byte address bit 2)
  localparam logic REG_YEAR_LOW  = 1'b0;
  localparam logic REG_YEAR_HIGH = 1'b1;

  localparam logic [13:0] YEAR_MAX        = 14'd9999;
  localparam logic [13:0] YEAR_LOW_RST    = 14'd2010;
  localparam logic [13:0] YEAR_HIGH_RST   = 14'd2020;
  localparam logic [3:0]  MONTH_FIRST     = 4'd1;
  localparam logic [3:0]  MONTH_LAST      = 4'd12;
  localparam logic [4:0]  DAY_FIRST       = 5'd1;
  localparam logic [4:0]  HOUR_LAST       = 5'd23;
  localparam logic [5:0]  MINUTE_LAST     = 6'd59;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } date_time_t;

  typedef struct packed {
    op_t        op;
    field_t     field_sel;
    date_time_t load;
  } req_t;

  // Saturated year window
  typedef struct packed {
    logic [13:0] lo;
    logic [13:0] hi;
  } year_bounds_t;

endpackage

`default_nettype wire

// File: rtl/dtfs_cfg.sv
`default_nettype none

module dtfs_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output dtfs_pkg::year_bounds_t          bounds
);

  logic [13:0] year_low_r;
  logic [13:0] year_high_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_low_r  <= dtfs_pkg::YEAR_LOW_RST;
      year_high_r <= dtfs_pkg::YEAR_HIGH_RST;
    end else if (wr_en) begin
      case (paddr[2])
        dtfs_pkg::REG_YEAR_LOW:  year_low_r  <= pwdata[13:0];
        dtfs_pkg::REG_YEAR_HIGH: year_high_r <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      dtfs_pkg::REG_YEAR_LOW:  prdata = {18'd0, year_low_r};
      dtfs_pkg::REG_YEAR_HIGH: prdata = {18'd0, year_high_r};
      default:                 prdata = 32'd0;
    endcase
  end

  // Values above the largest year act as the largest year
  assign bounds.lo = (year_low_r > dtfs_pkg::YEAR_MAX) ? dtfs_pkg::YEAR_MAX : year_low_r;
  assign bounds.hi = (year_high_r > dtfs_pkg::YEAR_MAX) ? dtfs_pkg::YEAR_MAX : year_high_r;

endmodule

`default_nettype wire

// File: rtl/dtfs_step.sv
`default_nettype none

module dtfs_step (
  input  wire dtfs_pkg::req_t          req,
  input  wire dtfs_pkg::date_time_t    cur,
  input  wire dtfs_pkg::year_bounds_t  bounds,
  output dtfs_pkg::date_time_t         nxt
);

  // 25 * 7209 == 1 mod 2^14: multiples of 25 map to 0..655
  localparam logic [13:0] INV25     = 14'd7209;
  localparam logic [13:0] DIV25_MAX = 14'd655;

  function automatic logic is_leap(input logic [13:0] y);
    logic [27:0] prod;
    logic        div25;
    prod  = y * INV25;
    div25 = (prod[13:0] <= DIV25_MAX);
    return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  logic [14:0] yr_inc;
  logic [13:0] yr_dec;
  logic [4:0]  cur_mlen;
  logic [4:0]  new_mlen;
  dtfs_pkg::date_time_t stepped;

  assign yr_inc   = {1'b0, cur.year} + 15'd1;
  assign yr_dec   = cur.year - 14'd1;
  assign cur_mlen = month_len(is_leap(cur.year), cur.month);

  always_comb begin
    stepped = cur;
    case (req.op)
      dtfs_pkg::OP_LOAD: begin
        stepped.year   = (req.load.year > dtfs_pkg::YEAR_MAX) ? dtfs_pkg::YEAR_MAX
                                                              : req.load.year;
        stepped.month  = (req.load.month == 4'd0) ? dtfs_pkg::MONTH_FIRST :
                         (req.load.month > dtfs_pkg::MONTH_LAST) ? dtfs_pkg::MONTH_LAST
                                                                 : req.load.month;
        stepped.day    = (req.load.day == 5'd0) ? dtfs_pkg::DAY_FIRST : req.load.day;
        stepped.hour   = (req.load.hour > dtfs_pkg::HOUR_LAST) ? dtfs_pkg::HOUR_LAST
                                                               : req.load.hour;
        stepped.minute = (req.load.minute > dtfs_pkg::MINUTE_LAST) ? dtfs_pkg::MINUTE_LAST
                                                                   : req.load.minute;
      end
      dtfs_pkg::OP_UP: begin
        case (req.field_sel)
          dtfs_pkg::FLD_YEAR:
            stepped.year = (yr_inc > {1'b0, bounds.hi}) ? bounds.lo : yr_inc[13:0];
          dtfs_pkg::FLD_MONTH:
            stepped.month = (cur.month >= dtfs_pkg::MONTH_LAST) ? dtfs_pkg::MONTH_FIRST
                                                                : cur.month + 4'd1;
          dtfs_pkg::FLD_DAY:
            stepped.day = (cur.day >= cur_mlen) ? dtfs_pkg::DAY_FIRST : cur.day + 5'd1;
          dtfs_pkg::FLD_HOUR:
            stepped.hour = (cur.hour >= dtfs_pkg::HOUR_LAST) ? 5'd0 : cur.hour + 5'd1;
          dtfs_pkg::FLD_MINUTE:
            stepped.minute = (cur.minute >= dtfs_pkg::MINUTE_LAST) ? 6'd0
                                                                   : cur.minute + 6'd1;
          default: ;
        endcase
      end
      dtfs_pkg::OP_DOWN: begin
        case (req.field_sel)
          dtfs_pkg::FLD_YEAR:
            stepped.year = ((cur.year == 14'd0) || (yr_dec < bounds.lo)) ? bounds.hi
                                                                          : yr_dec;
          dtfs_pkg::FLD_MONTH:
            stepped.month = (cur.month <= dtfs_pkg::MONTH_FIRST) ? dtfs_pkg::MONTH_LAST
                                                                 : cur.month - 4'd1;
          dtfs_pkg::FLD_DAY:
            stepped.day = (cur.day <= dtfs_pkg::DAY_FIRST) ? cur_mlen : cur.day - 5'd1;
          dtfs_pkg::FLD_HOUR:
            stepped.hour = (cur.hour == 5'd0) ? dtfs_pkg::HOUR_LAST : cur.hour - 5'd1;
          dtfs_pkg::FLD_MINUTE:
            stepped.minute = (cur.minute == 6'd0) ? dtfs_pkg::MINUTE_LAST
                                                  : cur.minute - 6'd1;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Clamp the day to the length of the resulting month
  assign new_mlen = month_len(is_leap(stepped.year), stepped.month);

  always_comb begin
    nxt = stepped;
    if (stepped.day > new_mlen) begin
      nxt.day = new_mlen;
    end
  end

endmodule

`default_nettype wire

// File: rtl/date_time_field_stepper_core.sv
`default_nettype none

// Channel   Direction  Handshake           Payload
// in_       request    in_valid/in_ready   op, field_sel, load_year..load_minute
// out_      result     out_valid/out_ready cur_year, cur_month, cur_day, cur_hour, cur_minute
// apb       config     psel/penable/pready year_low @ 0x0, year_high @ 0x4
//
// One request per cycle sustained while out_ready stays high; the input register loads at
// the accepting edge, and the date/time register that drives out_* loads from it once the
// result slot is free. That register is also the calendar state.
// rst_n is synchronous: fields to year 2010, month 1, day 1, 00:00; window 2010..2020.
// A stalled result holds the request in the input register; in_ready drops only
// when both the input register and the result are full and out_ready is low.

module date_time_field_stepper_core (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [2:0]  in_field_sel,
  input  wire logic [13:0] in_load_year,
  input  wire logic [3:0]  in_load_month,
  input  wire logic [4:0]  in_load_day,
  input  wire logic [4:0]  in_load_hour,
  input  wire logic [5:0]  in_load_minute,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [13:0]      out_cur_year,
  output logic [3:0]       out_cur_month,
  output logic [4:0]       out_cur_day,
  output logic [4:0]       out_cur_hour,
  output logic [5:0]       out_cur_minute,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  dtfs_pkg::year_bounds_t bounds;

  // Input register: holds one request while the result waits
  logic                 req_valid_r;
  logic                 req_valid_nxt;
  dtfs_pkg::req_t       req_r;
  dtfs_pkg::req_t       req_nxt;

  // Date/time register, also the result payload
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  dtfs_pkg::date_time_t dt_r;
  dtfs_pkg::date_time_t dt_nxt;

  logic                 in_fire;
  logic                 step_fire;

  dtfs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .bounds  (bounds)
  );

  dtfs_step u_step (
    .req    (req_r),
    .cur    (dt_r),
    .bounds (bounds),
    .nxt    (dt_nxt)
  );

  // Advance the held request whenever the result slot is free or being drained
  assign step_fire = req_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !req_valid_r || step_fire;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    req_nxt.op          = dtfs_pkg::op_t'(in_op);
    req_nxt.field_sel   = dtfs_pkg::field_t'(in_field_sel);
    req_nxt.load.year   = in_load_year;
    req_nxt.load.month  = in_load_month;
    req_nxt.load.day    = in_load_day;
    req_nxt.load.hour   = in_load_hour;
    req_nxt.load.minute = in_load_minute;
  end

  always_comb begin
    req_valid_nxt = req_valid_r;
    if (in_fire) begin
      req_valid_nxt = 1'b1;
    end else if (step_fire) begin
      req_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= req_nxt;
    end
  end

  // Outside reset, fields change only when a request moves into the result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r.year   <= dtfs_pkg::YEAR_LOW_RST;
      dt_r.month  <= dtfs_pkg::MONTH_FIRST;
      dt_r.day    <= dtfs_pkg::DAY_FIRST;
      dt_r.hour   <= 5'd0;
      dt_r.minute <= 6'd0;
    end else if (step_fire) begin
      dt_r <= dt_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cur_year   = dt_r.year;
  assign out_cur_month  = dt_r.month;
  assign out_cur_day    = dt_r.day;
  assign out_cur_hour   = dt_r.hour;
  assign out_cur_minute = dt_r.minute;

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 200_000;

  // Codes the block must leave untouched
  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam logic [2:0] FLD_SPARE_A = 3'd5;
  localparam logic [2:0] FLD_SPARE_C = 3'd7;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] sel;
    dtfs_pkg::date_time_t ld;
  } stim_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  wire         in_ready;
  logic [1:0]  in_op;
  logic [2:0]  in_field_sel;
  logic [13:0] in_load_year;
  logic [3:0]  in_load_month;
  logic [4:0]  in_load_day;
  logic [4:0]  in_load_hour;
  logic [5:0]  in_load_minute;
  wire         out_valid;
  logic        out_ready;
  wire  [13:0] out_cur_year;
  wire  [3:0]  out_cur_month;
  wire  [4:0]  out_cur_day;
  wire  [4:0]  out_cur_hour;
  wire  [5:0]  out_cur_minute;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  wire  [31:0] prdata;
  wire         pready;

  date_time_field_stepper_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_field_sel   (in_field_sel),
    .in_load_year   (in_load_year),
    .in_load_month  (in_load_month),
    .in_load_day    (in_load_day),
    .in_load_hour   (in_load_hour),
    .in_load_minute (in_load_minute),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cur_year   (out_cur_year),
    .out_cur_month  (out_cur_month),
    .out_cur_day    (out_cur_day),
    .out_cur_hour   (out_cur_hour),
    .out_cur_minute (out_cur_minute),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Shadow of the block: calendar fields and the year window
  dtfs_pkg::date_time_t clock_shadow;
  logic [13:0]          win_low;
  logic [13:0]          win_high;
  dtfs_pkg::date_time_t pending_dates[$];

  int unsigned cycles;
  int unsigned err_cnt;
  int unsigned sent_cnt;
  int unsigned checked_cnt;
  int unsigned window_writes;

  // Sender and receiver pacing knobs
  bit          pace_on;
  bit          rx_stall_on;
  int unsigned burst_left;
  logic [31:0] rx_pattern;
  int unsigned rx_pos;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Gregorian month length; out-of-range months count as January
  function automatic int days_in_month(int y, int m);
    int len;
    case (m)
      2:           len = (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
      4, 6, 9, 11: len = 30;
      default:     len = 31;
    endcase
    return len;
  endfunction

  // Apply one request to the calendar, then clamp the day to the month
  function automatic dtfs_pkg::date_time_t advance_clock(dtfs_pkg::date_time_t c, stim_t s);
    int y, m, d, h, n, lo, hi, len;
    dtfs_pkg::date_time_t r;
    y  = int'(c.year);
    m  = int'(c.month);
    d  = int'(c.day);
    h  = int'(c.hour);
    n  = int'(c.minute);
    lo = int'((win_low > dtfs_pkg::YEAR_MAX) ? dtfs_pkg::YEAR_MAX : win_low);
    hi = int'((win_high > dtfs_pkg::YEAR_MAX) ? dtfs_pkg::YEAR_MAX : win_high);
    case (s.op)
      dtfs_pkg::OP_LOAD: begin
        y = int'((s.ld.year > dtfs_pkg::YEAR_MAX) ? dtfs_pkg::YEAR_MAX : s.ld.year);
        if (s.ld.month < dtfs_pkg::MONTH_FIRST)     m = int'(dtfs_pkg::MONTH_FIRST);
        else if (s.ld.month > dtfs_pkg::MONTH_LAST) m = int'(dtfs_pkg::MONTH_LAST);
        else                                        m = int'(s.ld.month);
        d = int'((s.ld.day < dtfs_pkg::DAY_FIRST) ? dtfs_pkg::DAY_FIRST : s.ld.day);
        h = int'((s.ld.hour > dtfs_pkg::HOUR_LAST) ? dtfs_pkg::HOUR_LAST : s.ld.hour);
        n = int'((s.ld.minute > dtfs_pkg::MINUTE_LAST) ? dtfs_pkg::MINUTE_LAST
                                                        : s.ld.minute);
      end
      dtfs_pkg::OP_UP: begin
        case (s.sel)
          dtfs_pkg::FLD_YEAR:   y = (y + 1 > hi) ? lo : y + 1;
          dtfs_pkg::FLD_MONTH:  m = (m >= 12) ? 1 : m + 1;
          dtfs_pkg::FLD_DAY:    d = (d + 1 > days_in_month(y, m)) ? 1 : d + 1;
          dtfs_pkg::FLD_HOUR:   h = (h >= 23) ? 0 : h + 1;
          dtfs_pkg::FLD_MINUTE: n = (n >= 59) ? 0 : n + 1;
          default: ;
        endcase
      end
      dtfs_pkg::OP_DOWN: begin
        case (s.sel)
          dtfs_pkg::FLD_YEAR:   y = (y == 0 || y - 1 < lo) ? hi : y - 1;
          dtfs_pkg::FLD_MONTH:  m = (m <= 1) ? 12 : m - 1;
          dtfs_pkg::FLD_DAY:    d = (d <= 1) ? days_in_month(y, m) : d - 1;
          dtfs_pkg::FLD_HOUR:   h = (h == 0) ? 23 : h - 1;
          dtfs_pkg::FLD_MINUTE: n = (n == 0) ? 59 : n - 1;
          default: ;
        endcase
      end
      default: ;
    endcase
    len = days_in_month(y, m);
    if (d > len) d = len;
    r.year   = 14'(y);
    r.month  = 4'(m);
    r.day    = 5'(d);
    r.hour   = 5'(h);
    r.minute = 6'(n);
    return r;
  endfunction

  function automatic stim_t stim_of(logic [1:0] op, logic [2:0] sel,
                                    int y, int m, int d, int h, int n);
    stim_t s;
    s.op        = op;
    s.sel       = sel;
    s.ld.year   = 14'(y);
    s.ld.month  = 4'(m);
    s.ld.day    = 5'(d);
    s.ld.hour   = 5'(h);
    s.ld.minute = 6'(n);
    return s;
  endfunction

  // Mostly steps, some loads, a little noise on unused codes and wide load values
  function automatic stim_t random_req();
    stim_t s;
    int lo, hi, pick;
    lo   = int'((win_low > dtfs_pkg::YEAR_MAX) ? dtfs_pkg::YEAR_MAX : win_low);
    hi   = int'((win_high > dtfs_pkg::YEAR_MAX) ? dtfs_pkg::YEAR_MAX : win_high);
    pick = $urandom_range(0, 99);
    if (pick < 45)      s.op = dtfs_pkg::OP_UP;
    else if (pick < 82) s.op = dtfs_pkg::OP_DOWN;
    else if (pick < 96) s.op = dtfs_pkg::OP_LOAD;
    else                s.op = OP_SPARE;
    if ($urandom_range(0, 19) == 0) begin
      s.sel = 3'($urandom_range(FLD_SPARE_A, FLD_SPARE_C));
    end else begin
      s.sel = 3'($urandom_range(dtfs_pkg::FLD_YEAR, dtfs_pkg::FLD_MINUTE));
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: s.ld.year = 14'($urandom_range(lo, hi));
      6:       s.ld.year = 14'(100 * $urandom_range(16, 24));  // century leap rules
      7:       s.ld.year = 14'($urandom_range(0, dtfs_pkg::YEAR_MAX));
      8:       s.ld.year = 14'($urandom);
      default: s.ld.year = $urandom_range(0, 1) ? 14'd0 : 14'h3fff;
    endcase
    s.ld.month  = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(1, 12));
    s.ld.day    = 5'(($urandom_range(0, 2) == 0) ? $urandom_range(28, 31)
                                                  : $urandom_range(0, 31));
    s.ld.hour   = 5'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                  : $urandom_range(0, 23));
    s.ld.minute = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, 59));
    return s;
  endfunction

  // Send one request; open a random gap between bursts when pacing is on
  task automatic send_req(input stim_t s);
    int gap;
    if (pace_on && burst_left == 0) begin
      gap        = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid       <= 1'b1;
    in_op          <= s.op;
    in_field_sel   <= s.sel;
    in_load_year   <= s.ld.year;
    in_load_month  <= s.ld.month;
    in_load_day    <= s.ld.day;
    in_load_hour   <= s.ld.hour;
    in_load_minute <= s.ld.minute;
    do @(posedge clk); while (!in_ready);
    clock_shadow = advance_clock(clock_shadow, s);
    pending_dates.push_back(clock_shadow);
    sent_cnt++;
  endtask

  // Drop valid and wait until every result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_dates.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input logic idx, input logic [13:0] val);
    logic [17:0] junk;
    wait_idle();
    junk = ($urandom_range(0, 3) == 0) ? 18'($urandom) : 18'd0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == dtfs_pkg::REG_YEAR_LOW) win_low = val;
    else                               win_high = val;
    window_writes++;
  endtask

  task automatic run_random(input int n);
    repeat (n) send_req(random_req());
  endtask

  // Reset fields come back unchanged through the unused op
  task automatic test_reset_state();
    send_req(stim_of(OP_SPARE, dtfs_pkg::FLD_YEAR, 9999, 12, 31, 23, 59));
  endtask

  task automatic test_load_limits();
    send_req(stim_of(dtfs_pkg::OP_LOAD, dtfs_pkg::FLD_YEAR, 0, 0, 0, 0, 0));
    send_req(stim_of(dtfs_pkg::OP_LOAD, dtfs_pkg::FLD_YEAR, 16383, 15, 31, 31, 63));
    send_req(stim_of(dtfs_pkg::OP_LOAD, dtfs_pkg::FLD_YEAR, 9999, 12, 31, 23, 59));
    send_req(stim_of(dtfs_pkg::OP_LOAD, dtfs_pkg::FLD_YEAR, 10000, 13, 31, 24, 60));
  endtask

  // Walk every field across its wrap point in both directions
  task automatic test_field_wraps();
    send_req(stim_of(dtfs_pkg::OP_LOAD, dtfs_pkg::FLD_YEAR, 2020, 12, 31, 23, 59));
    send_req(stim_of(dtfs_pkg::OP_UP, dtfs_pkg::FLD_YEAR, 0, 0, 0, 0, 0));
    send_req(stim_of(dtfs_pkg::OP_UP, dtfs_pkg::FLD_MONTH, 0, 0, 0, 0, 0));
    send_req(stim_of(dtfs_pkg::OP_UP, dtfs_pkg::FLD_DAY, 0, 0, 0, 0, 0));
    send_req(stim_of(dtfs_pkg::OP_UP, dtfs_pkg::FLD_HOUR, 0, 0, 0, 0, 0));
    send_req(stim_of(dtfs_pkg::OP_UP, dtfs_pkg::FLD_MINUTE, 0, 0, 0, 0, 0));
    send_req(stim_of(dtfs_pkg::OP_DOWN, dtfs_pkg::FLD_MINUTE, 0, 0, 0, 0, 0));
    send_req(stim_of(dtfs_pkg::OP_DOWN, dtfs_pkg::FLD_HOUR, 0, 0, 0, 0, 0));
    send_req(stim_of(dtfs_pkg::OP_DOWN, dtfs_pkg::FLD_DAY, 0, 0, 0, 0, 0));
    send_req(stim_of(dtfs_pkg::OP_DOWN, dtfs_pkg::FLD_MONTH, 0, 0, 0, 0, 0));
    send_req(stim_of(dtfs_pkg::OP_DOWN, dtfs_pkg::FLD_YEAR, 0, 0, 0, 0, 0));
  endtask

  task automatic test_unused_codes();
    send_req(stim_of(dtfs_pkg::OP_UP, FLD_SPARE_A, 0, 0, 0, 0, 0));
    send_req(stim_of(dtfs_pkg::OP_DOWN, FLD_SPARE_C, 0, 0, 0, 0, 0));
    send_req(stim_of(dtfs_pkg::OP_UP, FLD_SPARE_A + 3'd1, 0, 0, 0, 0, 0));
    send_req(stim_of(OP_SPARE, FLD_SPARE_C, 1, 1, 1, 1, 1));
  endtask

  // Leap day, century rule and the day clamp after month and year steps
  task automatic test_leap_years();
    send_req(stim_of(dtfs_pkg::OP_LOAD, dtfs_pkg::FLD_YEAR, 2024, 1, 31, 12, 0));
    send_req(stim_of(dtfs_pkg::OP_UP, dtfs_pkg::FLD_MONTH, 0, 0, 0, 0, 0));
    send_req(stim_of(dtfs_pkg::OP_LOAD, dtfs_pkg::FLD_YEAR, 1900, 2, 30, 0, 0));
    send_req(stim_of(dtfs_pkg::OP_LOAD, dtfs_pkg::FLD_YEAR, 2020, 2, 29, 0, 0));
    send_req(stim_of(dtfs_pkg::OP_UP, dtfs_pkg::FLD_YEAR, 0, 0, 0, 0, 0));
    send_req(stim_of(dtfs_pkg::OP_UP, dtfs_pkg::FLD_DAY, 0, 0, 0, 0, 0));
  endtask

  // Year window at its extremes: full range, saturated, inverted
  task automatic test_year_window();
    write_window(dtfs_pkg::REG_YEAR_LOW, 14'd0);
    write_window(dtfs_pkg::REG_YEAR_HIGH, dtfs_pkg::YEAR_MAX);
    send_req(stim_of(dtfs_pkg::OP_LOAD, dtfs_pkg::FLD_YEAR, 0, 2, 29, 6, 30));
    send_req(stim_of(dtfs_pkg::OP_DOWN, dtfs_pkg::FLD_YEAR, 0, 0, 0, 0, 0));
    send_req(stim_of(dtfs_pkg::OP_UP, dtfs_pkg::FLD_YEAR, 0, 0, 0, 0, 0));
    write_window(dtfs_pkg::REG_YEAR_LOW, 14'h3fff);
    write_window(dtfs_pkg::REG_YEAR_HIGH, 14'h3fff);
    send_req(stim_of(dtfs_pkg::OP_UP, dtfs_pkg::FLD_YEAR, 0, 0, 0, 0, 0));
    send_req(stim_of(dtfs_pkg::OP_DOWN, dtfs_pkg::FLD_YEAR, 0, 0, 0, 0, 0));
    send_req(stim_of(dtfs_pkg::OP_UP, dtfs_pkg::FLD_YEAR, 0, 0, 0, 0, 0));
    write_window(dtfs_pkg::REG_YEAR_LOW, 14'd2030);
    write_window(dtfs_pkg::REG_YEAR_HIGH, 14'd2000);
    send_req(stim_of(dtfs_pkg::OP_LOAD, dtfs_pkg::FLD_YEAR, 2015, 6, 15, 8, 45));
    send_req(stim_of(dtfs_pkg::OP_UP, dtfs_pkg::FLD_YEAR, 0, 0, 0, 0, 0));
    send_req(stim_of(dtfs_pkg::OP_DOWN, dtfs_pkg::FLD_YEAR, 0, 0, 0, 0, 0));
  endtask

  // Random traffic under several window settings, one stretch with no idling
  task automatic test_random_windows();
    int lo;
    lo = $urandom_range(1990, 2100);
    write_window(dtfs_pkg::REG_YEAR_LOW, 14'(lo));
    write_window(dtfs_pkg::REG_YEAR_HIGH, 14'(lo + $urandom_range(0, 25)));
    run_random(130);
    write_window(dtfs_pkg::REG_YEAR_LOW, 14'd0);
    write_window(dtfs_pkg::REG_YEAR_HIGH, dtfs_pkg::YEAR_MAX);
    run_random(110);
    lo = $urandom_range(0, 9999);
    write_window(dtfs_pkg::REG_YEAR_LOW, 14'(lo));
    write_window(dtfs_pkg::REG_YEAR_HIGH, 14'(lo));
    run_random(80);
    write_window(dtfs_pkg::REG_YEAR_LOW, 14'($urandom_range(2000, 2050)));
    write_window(dtfs_pkg::REG_YEAR_HIGH, 14'($urandom_range(1950, 1999)));
    run_random(90);
    write_window(dtfs_pkg::REG_YEAR_LOW, 14'($urandom_range(9990, 16383)));
    write_window(dtfs_pkg::REG_YEAR_HIGH, 14'($urandom_range(10000, 16383)));
    run_random(80);
    write_window(dtfs_pkg::REG_YEAR_LOW, dtfs_pkg::YEAR_LOW_RST);
    write_window(dtfs_pkg::REG_YEAR_HIGH, dtfs_pkg::YEAR_HIGH_RST);
    pace_on     = 1'b0;
    rx_stall_on = 1'b0;
    run_random(110);
    pace_on     = 1'b1;
    rx_stall_on = 1'b1;
  endtask

  // Receiver: pick a new 32-bit ready pattern each window, sometimes stall-free
  always @(posedge clk) begin
    if (rx_pos == 0) begin
      case ($urandom_range(0, 3))
        0:       rx_pattern = '1;
        1:       rx_pattern = $urandom | $urandom;
        2:       rx_pattern = $urandom;
        default: rx_pattern = $urandom & $urandom;
      endcase
      if (!rx_stall_on) rx_pattern = '1;
    end
    out_ready <= rx_pattern[rx_pos];
    rx_pos = (rx_pos + 1) % 32;
  end

  task automatic compare_field(input string name, input logic [13:0] want,
                               input logic [13:0] got);
    if (got !== want) begin
      $display("%t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // Match each result against the oldest outstanding date
  always @(posedge clk) begin : result_check
    dtfs_pkg::date_time_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_dates.size() == 0) begin
        $display("%t: result with nothing outstanding, actual %0d-%0d-%0d %0d:%0d", $time,
                 out_cur_year, out_cur_month, out_cur_day, out_cur_hour, out_cur_minute);
        err_cnt++;
      end else begin
        want = pending_dates.pop_front();
        checked_cnt++;
        compare_field("year", want.year, out_cur_year);
        compare_field("month", 14'(want.month), 14'(out_cur_month));
        compare_field("day", 14'(want.day), 14'(out_cur_day));
        compare_field("hour", 14'(want.hour), 14'(out_cur_hour));
        compare_field("minute", 14'(want.minute), 14'(out_cur_minute));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%t: run timed out with %0d results outstanding", $time, pending_dates.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    cycles         = 0;
    err_cnt        = 0;
    sent_cnt       = 0;
    checked_cnt    = 0;
    window_writes  = 0;
    burst_left     = 0;
    rx_pos         = 0;
    rx_pattern     = '1;
    pace_on        = 1'b1;
    rx_stall_on    = 1'b1;
    win_low        = dtfs_pkg::YEAR_LOW_RST;
    win_high       = dtfs_pkg::YEAR_HIGH_RST;
    clock_shadow   = '{year: dtfs_pkg::YEAR_LOW_RST, month: dtfs_pkg::MONTH_FIRST,
                       day: dtfs_pkg::DAY_FIRST, hour: 5'd0, minute: 6'd0};
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_op          <= dtfs_pkg::OP_LOAD;
    in_field_sel   <= dtfs_pkg::FLD_YEAR;
    in_load_year   <= '0;
    in_load_month  <= '0;
    in_load_day    <= '0;
    in_load_hour   <= '0;
    in_load_minute <= '0;
    out_ready      <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_load_limits();
    test_field_wraps();
    test_unused_codes();
    test_leap_years();
    test_year_window();
    test_random_windows();

    // Hold until the pipeline is empty, then keep the clock running to catch strays
    wait_idle();
    repeat (6) @(posedge clk);

    $display("Sent %0d requests, compared %0d results, over %0d year-window writes",
             sent_cnt, checked_cnt, window_writes);
    $display("Loads, steps of every field, unused codes, leap rules and window extremes");
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
